// File: rtl/md2_message_digest_unit_assert.svh
// assertion macros for the md2 digest unit and its checker
// expects signals clk and rst_n in the scope where a macro is used
`ifndef MD2_MESSAGE_DIGEST_UNIT_ASSERT_SVH
`define MD2_MESSAGE_DIGEST_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define MD2_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define MD2_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/md2_pkg.sv
// shared constants, types and the s-box table of the md2 digest unit
// no dependencies
package md2_pkg;

    localparam int BYTE_W     = 8;
    localparam int BLK_BYTES  = 16;
    localparam int ROUNDS     = 18;
    localparam int WORK_STEPS = 48;
    localparam int MEM_DEPTH  = 64;
    localparam int MEM_ADDR_W = 6;

    typedef logic [BYTE_W-1:0]     byte_t;
    typedef logic [MEM_ADDR_W-1:0] maddr_t;

    // memory regions, selected by the two top address bits
    localparam logic [1:0] RGN_HASH = 2'b00;
    localparam logic [1:0] RGN_CKS  = 2'b01;
    localparam logic [1:0] RGN_WLO  = 2'b10;
    localparam logic [1:0] RGN_WHI  = 2'b11;

    localparam byte_t SBOX [256] = '{
        8'h29,8'h2E,8'h43,8'hC9,8'hA2,8'hD8,8'h7C,8'h01,
        8'h3D,8'h36,8'h54,8'hA1,8'hEC,8'hF0,8'h06,8'h13,
        8'h62,8'hA7,8'h05,8'hF3,8'hC0,8'hC7,8'h73,8'h8C,
        8'h98,8'h93,8'h2B,8'hD9,8'hBC,8'h4C,8'h82,8'hCA,
        8'h1E,8'h9B,8'h57,8'h3C,8'hFD,8'hD4,8'hE0,8'h16,
        8'h67,8'h42,8'h6F,8'h18,8'h8A,8'h17,8'hE5,8'h12,
        8'hBE,8'h4E,8'hC4,8'hD6,8'hDA,8'h9E,8'hDE,8'h49,
        8'hA0,8'hFB,8'hF5,8'h8E,8'hBB,8'h2F,8'hEE,8'h7A,
        8'hA9,8'h68,8'h79,8'h91,8'h15,8'hB2,8'h07,8'h3F,
        8'h94,8'hC2,8'h10,8'h89,8'h0B,8'h22,8'h5F,8'h21,
        8'h80,8'h7F,8'h5D,8'h9A,8'h5A,8'h90,8'h32,8'h27,
        8'h35,8'h3E,8'hCC,8'hE7,8'hBF,8'hF7,8'h97,8'h03,
        8'hFF,8'h19,8'h30,8'hB3,8'h48,8'hA5,8'hB5,8'hD1,
        8'hD7,8'h5E,8'h92,8'h2A,8'hAC,8'h56,8'hAA,8'hC6,
        8'h4F,8'hB8,8'h38,8'hD2,8'h96,8'hA4,8'h7D,8'hB6,
        8'h76,8'hFC,8'h6B,8'hE2,8'h9C,8'h74,8'h04,8'hF1,
        8'h45,8'h9D,8'h70,8'h59,8'h64,8'h71,8'h87,8'h20,
        8'h86,8'h5B,8'hCF,8'h65,8'hE6,8'h2D,8'hA8,8'h02,
        8'h1B,8'h60,8'h25,8'hAD,8'hAE,8'hB0,8'hB9,8'hF6,
        8'h1C,8'h46,8'h61,8'h69,8'h34,8'h40,8'h7E,8'h0F,
        8'h55,8'h47,8'hA3,8'h23,8'hDD,8'h51,8'hAF,8'h3A,
        8'hC3,8'h5C,8'hF9,8'hCE,8'hBA,8'hC5,8'hEA,8'h26,
        8'h2C,8'h53,8'h0D,8'h6E,8'h85,8'h28,8'h84,8'h09,
        8'hD3,8'hDF,8'hCD,8'hF4,8'h41,8'h81,8'h4D,8'h52,
        8'h6A,8'hDC,8'h37,8'hC8,8'h6C,8'hC1,8'hAB,8'hFA,
        8'h24,8'hE1,8'h7B,8'h08,8'h0C,8'hBD,8'hB1,8'h4A,
        8'h78,8'h88,8'h95,8'h8B,8'hE3,8'h63,8'hE8,8'h6D,
        8'hE9,8'hCB,8'hD5,8'hFE,8'h3B,8'h00,8'h1D,8'h39,
        8'hF2,8'hEF,8'hB7,8'h0E,8'h66,8'h58,8'hD0,8'hE4,
        8'hA6,8'h77,8'h72,8'hF8,8'hEB,8'h75,8'h4B,8'h0A,
        8'h31,8'h44,8'h50,8'hB4,8'h8F,8'hED,8'h1F,8'h1A,
        8'hDB,8'h99,8'h8D,8'h33,8'h9F,8'h11,8'h83,8'h14
    };

    // compression step 0..47 to memory address: hash bytes, then both work halves
    function automatic maddr_t work_addr(input logic [MEM_ADDR_W-1:0] k);
        maddr_t a;
        if (k[MEM_ADDR_W-1:MEM_ADDR_W-2] == 2'b00)
        begin
            a = k;
        end
        else
        begin
            a = k + MEM_ADDR_W'(BLK_BYTES);
        end
        return a;
    endfunction

endpackage

// File: rtl/md2_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module md2_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/md2_message_digest_unit.sv
// md2 digest unit: absorb one byte per beat, digest out as two 64-bit beats
// an absorb beat runs the byte states a, b and c; the 16th byte then starts the compression
// (48 entries x 18 rounds, one s-box lookup and one ram read-modify-write a cycle)
// finish: pad bytes through the byte states, compression, checksum block, compression, then the digest beats
// one beat in work at a time; async active-low reset clears control state,
// hash and checksum read as zero through per-entry valid flags, no clearing pass
module md2_message_digest_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] digest_word
    output logic        m_tuser,   // [0] word_index
    output logic        m_tlast    // last_word
);

    import md2_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_BYTE_A   = 3'd1;
    localparam logic [2:0] ST_BYTE_B   = 3'd2;
    localparam logic [2:0] ST_BYTE_C   = 3'd3;
    localparam logic [2:0] ST_COMP     = 3'd4;
    localparam logic [2:0] ST_OUT_RD   = 3'd5;
    localparam logic [2:0] ST_OUT_WAIT = 3'd6;

    localparam logic [3:0]            IDX_LAST   = 4'(BLK_BYTES - 1);
    localparam logic [MEM_ADDR_W-1:0] STEP_LAST  = MEM_ADDR_W'(WORK_STEPS - 1);
    localparam logic [4:0]            ROUND_LAST = 5'(ROUNDS - 1);

    logic [2:0]            state_reg, state_next;
    logic [3:0]            idx_reg, idx_next;
    logic [3:0]            fill_reg, fill_next;
    byte_t                 byte_reg, byte_next;
    byte_t                 lastc_reg, lastc_next;
    byte_t                 t_reg, t_next;
    logic                  fin_reg, fin_next;
    logic                  mode_reg, mode_next;
    logic                  half_reg, half_next;
    logic [15:0]           hv_reg, hv_next;
    logic [15:0]           cv_reg, cv_next;
    logic                  iss_on_reg, iss_on_next;
    logic [MEM_ADDR_W-1:0] iss_k_reg, iss_k_next;
    logic [4:0]            iss_r_reg, iss_r_next;
    logic                  pend_reg, pend_next;
    logic [MEM_ADDR_W-1:0] pend_k_reg, pend_k_next;
    logic [4:0]            pend_r_reg, pend_r_next;
    logic                  rd_mask_reg, rd_mask_next;
    logic [63:0]           word_reg, word_next;

    logic   rd_en;
    maddr_t rd_addr;
    byte_t  ram_rd_data;
    logic   wr_en;
    maddr_t wr_addr;
    byte_t  wr_data;
    byte_t  rdata_m;
    byte_t  new_byte;

    // state memory: hash, checksum and the two work halves
    md2_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // never-written hash and checksum entries read as zero
    function automatic logic entry_valid(input maddr_t a, input logic [15:0] hv,
                                         input logic [15:0] cv);
        logic v;
        if (a[MEM_ADDR_W-1:MEM_ADDR_W-2] == RGN_HASH)
        begin
            v = hv[a[3:0]];
        end
        else if (a[MEM_ADDR_W-1:MEM_ADDR_W-2] == RGN_CKS)
        begin
            v = cv[a[3:0]];
        end
        else
        begin
            v = 1'b1;
        end
        return v;
    endfunction

    assign rdata_m  = rd_mask_reg ? ram_rd_data : '0;
    assign new_byte = rdata_m ^ SBOX[t_reg];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT_WAIT);
    assign m_tdata  = word_reg;
    assign m_tuser  = half_reg;
    assign m_tlast  = half_reg;

    // sequencer and memory port control
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        fill_next    = fill_reg;
        byte_next    = byte_reg;
        lastc_next   = lastc_reg;
        t_next       = t_reg;
        fin_next     = fin_reg;
        mode_next    = mode_reg;
        half_next    = half_reg;
        hv_next      = hv_reg;
        cv_next      = cv_reg;
        iss_on_next  = iss_on_reg;
        iss_k_next   = iss_k_reg;
        iss_r_next   = iss_r_reg;
        pend_next    = 1'b0;
        pend_k_next  = pend_k_reg;
        pend_r_next  = pend_r_reg;
        word_next    = word_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    idx_next   = fill_reg;
                    mode_next  = 1'b0;
                    state_next = ST_BYTE_A;
                    if (s_tuser)
                    begin
                        // pad value is the count of missing bytes
                        fin_next  = 1'b1;
                        byte_next = {3'b000, 5'd16 - {1'b0, fill_reg}};
                    end
                    else
                    begin
                        fin_next  = 1'b0;
                        byte_next = s_tdata;
                    end
                end
            end

            ST_BYTE_A:
            begin
                // fetch checksum byte; when absorbing, store block byte in the low work half
                rd_en   = 1'b1;
                rd_addr = {RGN_CKS, idx_reg};
                if (!mode_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = {RGN_WLO, idx_reg};
                    wr_data = byte_reg;
                end
                state_next = ST_BYTE_B;
            end

            ST_BYTE_B:
            begin
                // fetch hash byte, update checksum or take it as the block byte
                rd_en   = 1'b1;
                rd_addr = {RGN_HASH, idx_reg};
                wr_en   = 1'b1;
                if (!mode_reg)
                begin
                    wr_addr    = {RGN_CKS, idx_reg};
                    wr_data    = rdata_m ^ SBOX[byte_reg ^ lastc_reg];
                    lastc_next = rdata_m ^ SBOX[byte_reg ^ lastc_reg];
                end
                else
                begin
                    wr_addr   = {RGN_WLO, idx_reg};
                    wr_data   = rdata_m;
                    byte_next = rdata_m;
                end
                state_next = ST_BYTE_C;
            end

            ST_BYTE_C:
            begin
                // high work half gets block byte xor hash byte
                wr_en   = 1'b1;
                wr_addr = {RGN_WHI, idx_reg};
                wr_data = byte_reg ^ rdata_m;
                if (idx_reg == IDX_LAST)
                begin
                    fill_next   = '0;
                    t_next      = '0;
                    iss_on_next = 1'b1;
                    iss_k_next  = '0;
                    iss_r_next  = '0;
                    state_next  = ST_COMP;
                end
                else
                begin
                    idx_next = idx_reg + 4'd1;
                    if (fin_reg)
                    begin
                        state_next = ST_BYTE_A;
                    end
                    else
                    begin
                        fill_next  = idx_reg + 4'd1;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_COMP:
            begin
                // issue one read a cycle, rounds of 48 entries
                if (iss_on_reg)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = work_addr(iss_k_reg);
                    pend_next   = 1'b1;
                    pend_k_next = iss_k_reg;
                    pend_r_next = iss_r_reg;
                    if (iss_k_reg == STEP_LAST)
                    begin
                        iss_k_next = '0;
                        if (iss_r_reg == ROUND_LAST)
                        begin
                            iss_on_next = 1'b0;
                        end
                        else
                        begin
                            iss_r_next = iss_r_reg + 5'd1;
                        end
                    end
                    else
                    begin
                        iss_k_next = iss_k_reg + MEM_ADDR_W'(1);
                    end
                end
                // s-box chain on the returning byte
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = work_addr(pend_k_reg);
                    wr_data = new_byte;
                    if (pend_k_reg == STEP_LAST)
                    begin
                        t_next = new_byte + {3'b000, pend_r_reg};
                    end
                    else
                    begin
                        t_next = new_byte;
                    end
                    if (pend_k_reg == STEP_LAST && pend_r_reg == ROUND_LAST)
                    begin
                        if (fin_reg && !mode_reg)
                        begin
                            mode_next  = 1'b1;
                            idx_next   = '0;
                            state_next = ST_BYTE_A;
                        end
                        else if (fin_reg)
                        begin
                            half_next   = 1'b0;
                            iss_on_next = 1'b1;
                            iss_k_next  = '0;
                            state_next  = ST_OUT_RD;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            ST_OUT_RD:
            begin
                // read eight hash bytes of one digest word
                if (iss_on_reg)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = {RGN_HASH, half_reg, iss_k_reg[2:0]};
                    pend_next   = 1'b1;
                    pend_k_next = iss_k_reg;
                    if (iss_k_reg[2:0] == 3'd7)
                    begin
                        iss_on_next = 1'b0;
                    end
                    else
                    begin
                        iss_k_next = iss_k_reg + MEM_ADDR_W'(1);
                    end
                end
                if (pend_reg)
                begin
                    word_next = {word_reg[55:0], rdata_m};
                    if (pend_k_reg[2:0] == 3'd7)
                    begin
                        state_next = ST_OUT_WAIT;
                    end
                end
            end

            ST_OUT_WAIT:
            begin
                if (m_tready)
                begin
                    if (!half_reg)
                    begin
                        half_next   = 1'b1;
                        iss_on_next = 1'b1;
                        iss_k_next  = '0;
                        state_next  = ST_OUT_RD;
                    end
                    else
                    begin
                        // back to the empty-message state
                        half_next  = 1'b0;
                        fin_next   = 1'b0;
                        mode_next  = 1'b0;
                        fill_next  = '0;
                        lastc_next = '0;
                        hv_next    = '0;
                        cv_next    = '0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // mark hash and checksum entries once written
        if (wr_en && wr_addr[MEM_ADDR_W-1:MEM_ADDR_W-2] == RGN_HASH)
        begin
            hv_next[wr_addr[3:0]] = 1'b1;
        end
        if (wr_en && wr_addr[MEM_ADDR_W-1:MEM_ADDR_W-2] == RGN_CKS)
        begin
            cv_next[wr_addr[3:0]] = 1'b1;
        end

        rd_mask_next = rd_en ? entry_valid(rd_addr, hv_reg, cv_reg) : rd_mask_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            fill_reg    <= '0;
            lastc_reg   <= '0;
            t_reg       <= '0;
            fin_reg     <= 1'b0;
            mode_reg    <= 1'b0;
            half_reg    <= 1'b0;
            hv_reg      <= '0;
            cv_reg      <= '0;
            iss_on_reg  <= 1'b0;
            iss_k_reg   <= '0;
            iss_r_reg   <= '0;
            pend_reg    <= 1'b0;
            pend_k_reg  <= '0;
            pend_r_reg  <= '0;
            rd_mask_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            fill_reg    <= fill_next;
            lastc_reg   <= lastc_next;
            t_reg       <= t_next;
            fin_reg     <= fin_next;
            mode_reg    <= mode_next;
            half_reg    <= half_next;
            hv_reg      <= hv_next;
            cv_reg      <= cv_next;
            iss_on_reg  <= iss_on_next;
            iss_k_reg   <= iss_k_next;
            iss_r_reg   <= iss_r_next;
            pend_reg    <= pend_next;
            pend_k_reg  <= pend_k_next;
            pend_r_reg  <= pend_r_next;
            rd_mask_reg <= rd_mask_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        word_reg <= word_next;
    end

endmodule

// File: rtl/md2_chk.sv
// port-level checker for the md2 digest unit, bound to the top level
// depends on md2_message_digest_unit_assert.svh
`include "md2_message_digest_unit_assert.svh"

module md2_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // a stalled digest beat holds
    `MD2_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "digest beat changed while stalled")

    // no input taken while a digest beat is offered
    `MD2_ASSERT_NOW(a_busy_out, m_tvalid, !s_tready, "input ready during digest output")

    // word index and last flag agree
    `MD2_ASSERT_NOW(a_idx_last, m_tvalid, m_tuser == m_tlast, "word index does not match last flag")

    // after the first word, the second one is fetched before anything else
    `MD2_ASSERT_NEXT(a_first_gap, m_tvalid && m_tready && !m_tlast, !m_tvalid && !s_tready, "no gap after first digest word")

    // the final word frees the block at once
    `MD2_ASSERT_NEXT(a_last_idle, m_tvalid && m_tready && m_tlast, s_tready && !m_tvalid, "block not idle after final digest word")

endmodule

bind md2_message_digest_unit md2_chk md2_chk_i (.*);

// File: tb/tb.sv
// testbench for md2_message_digest_unit: byte messages go in, two digest beats come out
// an md2 predictor built into this file checks every digest beat
// depends on md2_pkg (s-box table, block size, round count) and the unit itself
module tb;
    import md2_pkg::*;

    localparam logic OP_ABSORB      = 1'b0;
    localparam logic OP_FINISH      = 1'b1;
    localparam int   IDLE_PCT       = 7;
    localparam int   RAND_ITEMS     = 800;
    localparam int   QUIET_FROM     = 300;
    localparam int   QUIET_TO       = 460;
    localparam int   HOLD_AT_DIGEST = 12;
    localparam int   HOLD_CYCLES    = 3000;
    localparam int   STALL_LIMIT    = 20000;
    localparam int   TAIL_CYCLES    = 50;

    typedef struct {
        logic       op;
        logic [7:0] data;
        bit         drain;
    } msg_beat_t;

    typedef struct packed {
        logic [63:0] word;
        logic        idx;
        logic        last;
    } digest_beat_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
    logic        s_tuser  = 1'b0;    // [0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;            // [63:0] digest_word
    logic        m_tuser;            // [0] word_index
    logic        m_tlast;            // last_word

    msg_beat_t    pending_q [$];
    digest_beat_t digest_q [$];

    // predictor state
    byte_t hash_st [16];
    byte_t cks [16];
    byte_t blk_buf [16];
    int    fill;

    int   items_taken   = 0;
    int   digests_taken = 0;
    int   errors        = 0;
    logic in_taken      = 1'b0;
    logic quiet;
    int   hold_left     = 0;
    bit   hold_done     = 1'b0;
    int   stall_cnt     = 0;

    assign quiet = (items_taken >= QUIET_FROM) && (items_taken < QUIET_TO);

    md2_message_digest_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // back to the state of a fresh message
    function automatic void md2_clear();
        int i;
        for (i = 0; i < BLK_BYTES; i++)
        begin
            hash_st[i] = 8'h00;
            cks[i]     = 8'h00;
            blk_buf[i] = 8'h00;
        end
        fill = 0;
    endfunction

    // checksum update, then 18 rounds over hash state and the 32-byte work area
    function automatic void md2_fold_block(input logic [127:0] blk);
        byte_t t;
        byte_t ws [32];
        int    i;
        int    r;
        t = cks[BLK_BYTES-1];
        for (i = 0; i < BLK_BYTES; i++)
        begin
            cks[i] = cks[i] ^ SBOX[blk[8*i +: 8] ^ t];
            t = cks[i];
        end
        for (i = 0; i < BLK_BYTES; i++)
        begin
            ws[i]             = blk[8*i +: 8];
            ws[BLK_BYTES + i] = blk[8*i +: 8] ^ hash_st[i];
        end
        t = 8'h00;
        for (r = 0; r < ROUNDS; r++)
        begin
            for (i = 0; i < BLK_BYTES; i++)
            begin
                hash_st[i] = hash_st[i] ^ SBOX[t];
                t = hash_st[i];
            end
            for (i = 0; i < 2*BLK_BYTES; i++)
            begin
                ws[i] = ws[i] ^ SBOX[t];
                t = ws[i];
            end
            t = t + byte_t'(r);
        end
    endfunction

    // one accepted input beat: absorb a byte, or pad, finish and queue the digest
    function automatic void md2_take(input logic op, input logic [7:0] data);
        logic [127:0] blk;
        logic [63:0]  word;
        digest_beat_t b;
        int           i;
        int           w;
        if (op == OP_ABSORB)
        begin
            blk_buf[fill] = data;
            if (fill == BLK_BYTES - 1)
            begin
                for (i = 0; i < BLK_BYTES; i++)
                    blk[8*i +: 8] = blk_buf[i];
                md2_fold_block(blk);
                for (i = 0; i < BLK_BYTES; i++)
                    blk_buf[i] = 8'h00;
                fill = 0;
            end
            else
            begin
                fill = fill + 1;
            end
        end
        else
        begin
            // pad with n bytes of value n, a whole block of 16s when empty
            for (i = fill; i < BLK_BYTES; i++)
                blk_buf[i] = 8'(BLK_BYTES - fill);
            for (i = 0; i < BLK_BYTES; i++)
                blk[8*i +: 8] = blk_buf[i];
            md2_fold_block(blk);
            for (i = 0; i < BLK_BYTES; i++)
                blk[8*i +: 8] = cks[i];
            md2_fold_block(blk);
            for (w = 0; w < 2; w++)
            begin
                word = 64'h0;
                for (i = 0; i < 8; i++)
                    word = {word[55:0], hash_st[w*8 + i]};
                b.word = word;
                b.idx  = (w == 1);
                b.last = (w == 1);
                digest_q.push_back(b);
            end
            md2_clear();
        end
    endfunction

    task automatic push_beat(input logic op, input logic [7:0] data, input bit drain);
        msg_beat_t b;
        b.op    = op;
        b.data  = data;
        b.drain = drain;
        pending_q.push_back(b);
    endtask

    // random message of len bytes plus its finish beat
    task automatic push_message(input int len, input bit drain);
        int i;
        for (i = 0; i < len; i++)
            push_beat(OP_ABSORB, 8'($urandom), drain && (i == 0));
        push_beat(OP_FINISH, 8'($urandom), drain && (len == 0));
    endtask

    // stimulus, reset and end of run
    initial
    begin
        int n;
        int msg_no;
        int sel;
        int len;
        int i;
        md2_clear();

        // empty message, data ignored on finish
        push_beat(OP_FINISH, 8'hFF, 1'b0);
        // two-byte message at both byte extremes
        push_beat(OP_ABSORB, 8'h00, 1'b0);
        push_beat(OP_ABSORB, 8'hFF, 1'b0);
        push_beat(OP_FINISH, 8'h00, 1'b0);
        // exactly one block, so the finish pads a whole block of 16s
        for (i = 0; i < BLK_BYTES; i++)
            push_beat(OP_ABSORB, (i % 2 == 1) ? 8'hFF : 8'h00, 1'b0);
        push_beat(OP_FINISH, 8'hA5, 1'b0);

        // random messages, mostly short, with block edges favored
        n      = 0;
        msg_no = 0;
        while (n < RAND_ITEMS)
        begin
            sel = $urandom_range(99);
            if (sel < 12)
                len = BLK_BYTES * $urandom_range(1, 2);
            else if (sel < 20)
                len = BLK_BYTES - 1;
            else if (sel < 24)
                len = $urandom_range(33, 48);
            else
                len = $urandom_range(0, 20);
            push_message(len, (msg_no == 5) || ($urandom_range(19) == 0));
            n      = n + len + 1;
            msg_no = msg_no + 1;
        end

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // input driver: next beat once the current one is taken, random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (pending_q.size() != 0
                && !(pending_q[0].drain && digest_q.size() != 0)
                && (quiet || $urandom_range(99) >= IDLE_PCT))
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_q[0].op;
                s_tdata  <= pending_q[0].data;
                void'(pending_q.pop_front());
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output ready: random stalls plus one long hold-off to back up the input
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                m_tready  <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && digests_taken >= HOLD_AT_DIGEST)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end
            else
            begin
                m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // monitor: check digest beats, feed accepted input beats to the predictor
    always @(posedge clk)
    begin
        digest_beat_t exp_b;
        in_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (digest_q.size() == 0)
                begin
                    $display("%0t: unexpected digest beat, expected none, actual %h idx %b last %b",
                             $time, m_tdata, m_tuser, m_tlast);
                    errors = errors + 1;
                end
                else
                begin
                    exp_b = digest_q.pop_front();
                    if (m_tdata !== exp_b.word)
                    begin
                        $display("%0t: digest word mismatch, expected %h, actual %h",
                                 $time, exp_b.word, m_tdata);
                        errors = errors + 1;
                    end
                    if (m_tuser !== exp_b.idx)
                    begin
                        $display("%0t: word index mismatch, expected %b, actual %b",
                                 $time, exp_b.idx, m_tuser);
                        errors = errors + 1;
                    end
                    if (m_tlast !== exp_b.last)
                    begin
                        $display("%0t: last word mismatch, expected %b, actual %b",
                                 $time, exp_b.last, m_tlast);
                        errors = errors + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                md2_take(s_tuser, s_tdata);
                items_taken = items_taken + 1;
                if (s_tuser == OP_FINISH)
                    digests_taken = digests_taken + 1;
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/md2_pkg.sv
rtl/md2_ram.sv
rtl/md2_message_digest_unit.sv
rtl/md2_chk.sv
tb/tb.sv
